/* rtl/core/m68k_effective_address_unit_macros.svh */
// ---------------------------------------------------------------------------
// m68k effective address unit assertion macros
// Shared assertion wrappers for the effective address unit RTL.
// ---------------------------------------------------------------------------
`ifndef M68K_EFFECTIVE_ADDRESS_UNIT_MACROS_SVH
`define M68K_EFFECTIVE_ADDRESS_UNIT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define M68K_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset
`define M68K_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/m68k_ea_pkg.sv */
// ---------------------------------------------------------------------------
// m68k_ea_pkg
// Types, codes and helpers shared by the effective address unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package m68k_ea_pkg;

  // Input word kinds (carried on tuser)
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  // Addressing modes
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_EXT     = 3'd7;

  // Mode 7 sub-modes
  localparam logic [2:0] SUB_ABS_SHORT = 3'd0;
  localparam logic [2:0] SUB_ABS_LONG  = 3'd1;
  localparam logic [2:0] SUB_PC_DISP   = 3'd2;
  localparam logic [2:0] SUB_PC_INDEX  = 3'd3;

  // Operand sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // Displacement size codes in the full extension word
  localparam logic [1:0] DSZ_WORD = 2'd2;
  localparam logic [1:0] DSZ_LONG = 2'd3;

  localparam logic [2:0] SP_REG = 3'd7;

  // Configuration register map
  localparam int unsigned CfgAddrW  = 3;
  localparam logic        REG_CPU   = 1'b0;

  typedef enum logic [1:0] {
    KIND_FINAL   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_INVALID = 2'd2
  } kind_e;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [1:0]  size;
    logic [31:0] an_value;
    logic [31:0] pc_value;
    logic [15:0] ext_word;
    logic [31:0] index_value;
    logic [31:0] base_disp_words;
    logic [31:0] outer_disp_words;
    logic [31:0] mem_data;
  } item_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [31:0] address;
    logic        an_write_enable;
    logic [31:0] an_new_value;
    logic [3:0]  extra_cycles;
    logic        ext020_used;
    logic        full_format_030;
  } result_t;

  // Indirection state carried between words
  typedef struct packed {
    logic        pending;
    logic [31:0] post_index;
    logic [31:0] outer_disp;
  } ind_state_t;

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

/* rtl/core/m68k_ea_calc.sv */
// ---------------------------------------------------------------------------
// m68k_ea_calc
// Combinational address datapath: mode decode, index extension, An update
// and completion of memory-indirect forms.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module m68k_ea_calc (
  input  m68k_ea_pkg::item_t      item_i,
  input  logic                    is030_i,
  input  m68k_ea_pkg::ind_state_t st_i,
  output m68k_ea_pkg::result_t    res_o,
  output m68k_ea_pkg::ind_state_t st_o
);

  logic [31:0] base;
  logic [15:0] ext;
  logic [1:0]  scale;
  logic        full;
  logic        base_sup;
  logic        idx_sup;
  logic [1:0]  bdsz;
  logic [2:0]  iis;
  logic        post;
  logic        e020;
  logic [31:0] idx_ext;
  logic [31:0] idx_sc;
  logic [31:0] idx_s;
  logic [31:0] base_s;
  logic [31:0] bd;
  logic [31:0] od;
  logic [31:0] brief_addr;
  logic [31:0] inner_sum;
  logic [3:0]  bd_extra;
  logic [3:0]  full_extra;
  logic [31:0] step;
  logic [31:0] sd16;

  // Index extension fields
  assign ext      = item_i.ext_word;
  assign base     = (item_i.mode == m68k_ea_pkg::MODE_INDEX) ? item_i.an_value
                                                              : item_i.pc_value;
  assign scale    = ext[10:9];
  assign full     = ext[8];
  assign base_sup = ext[7];
  assign idx_sup  = ext[6];
  assign bdsz     = ext[5:4];
  assign iis      = ext[2:0];
  assign post     = iis[2];
  assign e020     = full | (scale != 2'd0);
  assign sd16     = m68k_ea_pkg::sext16(ext);

  // Scaled index, word index sign-extended
  assign idx_ext = ext[11] ? item_i.index_value
                           : m68k_ea_pkg::sext16(item_i.index_value[15:0]);
  assign idx_sc  = idx_ext << scale;
  assign idx_s   = idx_sup ? 32'd0 : idx_sc;
  assign base_s  = base_sup ? 32'd0 : base;

  // Base and outer displacements; null and reserved sizes give zero
  always_comb begin
    unique case (bdsz)
      m68k_ea_pkg::DSZ_WORD: bd = m68k_ea_pkg::sext16(item_i.base_disp_words[15:0]);
      m68k_ea_pkg::DSZ_LONG: bd = item_i.base_disp_words;
      default:               bd = 32'd0;
    endcase
    unique case (iis[1:0])
      m68k_ea_pkg::DSZ_WORD: od = m68k_ea_pkg::sext16(item_i.outer_disp_words[15:0]);
      m68k_ea_pkg::DSZ_LONG: od = item_i.outer_disp_words;
      default:               od = 32'd0;
    endcase
  end

  assign brief_addr = base + m68k_ea_pkg::sext8(ext[7:0]) + idx_sc;
  // post-indexed forms leave the index out of the intermediate address
  assign inner_sum  = base_s + bd + (post ? 32'd0 : idx_s);

  // Extra clock charge for the full format
  assign bd_extra   = (bdsz == m68k_ea_pkg::DSZ_LONG) ? 4'd6 :
                      ((bdsz == m68k_ea_pkg::DSZ_WORD) && base_sup) ? 4'd2 : 4'd0;
  assign full_extra = (is030_i ? 4'd0 : 4'd2)
                    + ((iis != 3'd0) ? 4'd4 : 4'd0)
                    + (is030_i ? bd_extra : 4'd0)
                    + ((is030_i && (iis != 3'd0) && iis[1]) ? 4'd2 : 4'd0);

  // Postincrement / predecrement step; byte on A7 keeps the stack even
  always_comb begin
    if (item_i.size == m68k_ea_pkg::SIZE_BYTE) begin
      step = (item_i.reg_req == m68k_ea_pkg::SP_REG) ? 32'd2 : 32'd1;
    end else if (item_i.size == m68k_ea_pkg::SIZE_WORD) begin
      step = 32'd2;
    end else begin
      step = 32'd4;
    end
  end

  // Result and next indirection state
  always_comb begin
    res_o.result_kind     = m68k_ea_pkg::KIND_INVALID;
    res_o.address         = 32'd0;
    res_o.an_write_enable = 1'b0;
    res_o.an_new_value    = 32'd0;
    res_o.extra_cycles    = 4'd0;
    res_o.ext020_used     = 1'b0;
    res_o.full_format_030 = 1'b0;
    st_o.pending          = 1'b0;
    st_o.post_index       = st_i.post_index;
    st_o.outer_disp       = st_i.outer_disp;

    if (item_i.opcode == m68k_ea_pkg::OP_DATA) begin
      if (st_i.pending) begin
        res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
        res_o.address     = item_i.mem_data + st_i.post_index + st_i.outer_disp;
      end
    end else begin
      unique case (item_i.mode)
        m68k_ea_pkg::MODE_IND: begin
          res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
          res_o.address     = item_i.an_value;
        end
        m68k_ea_pkg::MODE_POSTINC: begin
          res_o.result_kind     = m68k_ea_pkg::KIND_FINAL;
          res_o.address         = item_i.an_value;
          res_o.an_write_enable = 1'b1;
          res_o.an_new_value    = item_i.an_value + step;
        end
        m68k_ea_pkg::MODE_PREDEC: begin
          res_o.result_kind     = m68k_ea_pkg::KIND_FINAL;
          res_o.address         = item_i.an_value - step;
          res_o.an_write_enable = 1'b1;
          res_o.an_new_value    = item_i.an_value - step;
        end
        m68k_ea_pkg::MODE_DISP: begin
          res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
          res_o.address     = item_i.an_value + sd16;
        end
        m68k_ea_pkg::MODE_INDEX, m68k_ea_pkg::MODE_EXT: begin
          if ((item_i.mode == m68k_ea_pkg::MODE_INDEX) ||
              (item_i.reg_req == m68k_ea_pkg::SUB_PC_INDEX)) begin
            res_o.ext020_used = e020;
            if (!full) begin
              res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
              res_o.address     = brief_addr;
            end else begin
              res_o.address         = inner_sum;
              res_o.extra_cycles    = full_extra;
              res_o.full_format_030 = is030_i;
              if (iis == 3'd0) begin
                res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
              end else begin
                res_o.result_kind = m68k_ea_pkg::KIND_READ;
                st_o.pending      = 1'b1;
                st_o.post_index   = post ? idx_s : 32'd0;
                st_o.outer_disp   = od;
              end
            end
          end else if (item_i.reg_req == m68k_ea_pkg::SUB_ABS_SHORT) begin
            res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
            res_o.address     = sd16;
          end else if (item_i.reg_req == m68k_ea_pkg::SUB_ABS_LONG) begin
            res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
            res_o.address     = item_i.base_disp_words;
          end else if (item_i.reg_req == m68k_ea_pkg::SUB_PC_DISP) begin
            res_o.result_kind = m68k_ea_pkg::KIND_FINAL;
            res_o.address     = item_i.pc_value + sd16;
          end
        end
        default: begin
          res_o.result_kind = m68k_ea_pkg::KIND_INVALID;
        end
      endcase
    end
  end

endmodule

/* rtl/core/m68k_effective_address_unit.sv */
// Effective address unit: takes one word per clock and returns exactly one
// result word per input word, in order. Each result passes through the input
// register, then the result register, before it is offered. Throughput is
// one word per clock as long as the result side takes words; the result
// register is the only point of back-pressure. A memory-indirect form returns
// a read request; the data word that follows (tuser = 1) is combined with the
// held post-index and outer displacement, and any other compute word in
// between drops the pending indirection.
// ---------------------------------------------------------------------------
// m68k_effective_address_unit
// 68020-class effective address generator, modes 2 through 7.3, with an
// APB-style timing select register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "m68k_effective_address_unit_macros.svh"

module m68k_effective_address_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // mode[2:0] reg_req[5:3] size[7:6] an_value[39:8] pc_value[71:40]
  // ext_word[87:72] index_value[119:88] base_disp_words[151:120]
  // outer_disp_words[183:152] mem_data[215:184]
  input  logic [215:0]                     s_tdata,
  // opcode[0]
  input  logic                             s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // address[31:0] an_write_enable[32] an_new_value[64:33] extra_cycles[68:65]
  // ext020_used[69] full_format_030[70] zero[71]
  output logic [71:0]                      m_tdata,
  // result_kind[1:0]
  output logic [1:0]                       m_tuser,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [m68k_ea_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic                    cpu030_q;
  logic                    in_valid_q;
  m68k_ea_pkg::item_t      in_q;
  logic                    out_valid_q;
  m68k_ea_pkg::result_t    out_q;
  m68k_ea_pkg::result_t    res_d;
  m68k_ea_pkg::ind_state_t st_q;
  m68k_ea_pkg::ind_state_t st_d;
  m68k_ea_pkg::item_t      in_d;
  logic                    advance;
  logic                    retire;
  logic                    cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready &
                  (paddr[m68k_ea_pkg::CfgAddrW-1] == m68k_ea_pkg::REG_CPU);
  assign prdata = (paddr[m68k_ea_pkg::CfgAddrW-1] == m68k_ea_pkg::REG_CPU)
                  ? {31'd0, cpu030_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu030_q <= 1'b0;
    end else if (cfg_wr) begin
      cpu030_q <= pwdata[0];
    end
  end

  // Unpack the input word
  assign in_d.opcode           = s_tuser;
  assign in_d.mode             = s_tdata[2:0];
  assign in_d.reg_req          = s_tdata[5:3];
  assign in_d.size             = s_tdata[7:6];
  assign in_d.an_value         = s_tdata[39:8];
  assign in_d.pc_value         = s_tdata[71:40];
  assign in_d.ext_word         = s_tdata[87:72];
  assign in_d.index_value      = s_tdata[119:88];
  assign in_d.base_disp_words  = s_tdata[151:120];
  assign in_d.outer_disp_words = s_tdata[183:152];
  assign in_d.mem_data         = s_tdata[215:184];

  // Pipeline flow: result register frees or drains, input stage follows
  assign advance  = !out_valid_q || m_tready;
  assign retire   = in_valid_q && advance;
  assign s_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_q <= in_d;
    end
  end

  m68k_ea_calc u_calc (
    .item_i  (in_q),
    .is030_i (cpu030_q),
    .st_i    (st_q),
    .res_o   (res_d),
    .st_o    (st_d)
  );

  // Indirection state updates as each word retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (retire) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      out_q <= res_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tuser  = out_q.result_kind;
  assign m_tdata  = {1'b0, out_q.full_format_030, out_q.ext020_used,
                     out_q.extra_cycles, out_q.an_new_value,
                     out_q.an_write_enable, out_q.address};

  // Checks
  `M68K_ASSERT(a_read_sets_pending, clk_i, rst_ni,
    retire && (res_d.result_kind == m68k_ea_pkg::KIND_READ) |=> st_q.pending,
    "read request retired without pending indirection")
  `M68K_ASSERT(a_invalid_zero, clk_i, rst_ni,
    m_tvalid && (m_tuser == m68k_ea_pkg::KIND_INVALID) |-> (m_tdata == 72'd0),
    "invalid result carries nonzero payload")
  `M68K_ASSERT(a_wb_final, clk_i, rst_ni,
    m_tvalid && m_tdata[32] |-> (m_tuser == m68k_ea_pkg::KIND_FINAL),
    "An write-back on a non-final result")
  `M68K_ASSERT(a_stall_cause, clk_i, rst_ni,
    !s_tready |-> (in_valid_q && out_valid_q && !m_tready),
    "input stalled without a full pipeline")

endmodule

/* sim/tb_m68k_effective_address_unit.sv */
// ---------------------------------------------------------------------------
// tb_m68k_effective_address_unit
// Self-checking bench for the effective address unit. A queue-fed driver
// pushes address words into the input stream and predicts each result in
// the bench itself. A monitor pops those predictions and compares them field
// by field with the result stream. Directed words come first, then random
// streams that are mostly indirect sequences, under both timing settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_m68k_effective_address_unit;

  localparam int unsigned RUN_LIMIT   = 400000;
  localparam logic [7:0]  HOLD_CYCLES = 8'd150;

  // Codes the package leaves out
  localparam logic [2:0] MODE_DREG = 3'd0;
  localparam logic [2:0] MODE_AREG = 3'd1;
  localparam logic [2:0] SUB_IMM   = 3'd4;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  // Extension word bit positions
  localparam int unsigned XB_LONG_IDX = 11;
  localparam int unsigned XB_FULL     = 8;
  localparam int unsigned XB_BS       = 7;
  localparam int unsigned XB_IS       = 6;

  logic                             clk_i    = 1'b0;
  logic                             rst_ni   = 1'b0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [215:0]                     s_tdata  = '0;
  logic                             s_tuser  = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [71:0]                      m_tdata;
  logic [1:0]                       m_tuser;
  logic                             psel     = 1'b0;
  logic                             penable  = 1'b0;
  logic                             pwrite   = 1'b0;
  logic [m68k_ea_pkg::CfgAddrW-1:0] paddr    = '0;
  logic [31:0]                      pwdata   = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  m68k_effective_address_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Words waiting to go out, and results still owed by the block
  m68k_ea_pkg::item_t   ea_items[$];
  m68k_ea_pkg::result_t ea_expected[$];

  // Shadow of the timing register and of the indirection state
  logic        cfg_is_030 = 1'b0;
  logic        ind_pend   = 1'b0;
  logic [31:0] held_post  = '0;
  logic [31:0] held_outer = '0;

  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_ack   = 0;
  int unsigned words_in   = 0;
  int unsigned results_out = 0;
  int unsigned reads_out  = 0;
  int unsigned invalid_out = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cyc        = 0;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return 32'($signed(v));
  endfunction

  // Index extension forms (brief and full) on the given base
  function automatic m68k_ea_pkg::result_t index_form(logic [31:0] base,
                                                      m68k_ea_pkg::item_t it);
    m68k_ea_pkg::result_t r;
    logic [15:0] ext;
    logic [1:0]  scale, bdsz, odsz;
    logic [2:0]  iis;
    logic [31:0] idx, bd, od;
    logic [3:0]  extra;
    logic        post;
    r     = '0;
    ext   = it.ext_word;
    scale = ext[10:9];
    r.ext020_used = ext[XB_FULL] || (scale != 2'd0);
    idx = ext[XB_LONG_IDX] ? it.index_value : sx16(it.index_value[15:0]);
    idx = idx << scale;
    if (!ext[XB_FULL]) begin
      r.address = base + 32'($signed(ext[7:0])) + idx;
      return r;
    end
    extra = cfg_is_030 ? 4'd0 : 4'd2;
    if (ext[XB_BS]) base = '0;
    bdsz = ext[5:4];
    bd = (bdsz == m68k_ea_pkg::DSZ_WORD) ? sx16(it.base_disp_words[15:0]) :
         (bdsz == m68k_ea_pkg::DSZ_LONG) ? it.base_disp_words : 32'd0;
    if (ext[XB_IS]) idx = '0;
    // 030 charges for long base, or word base with the base suppressed
    if (cfg_is_030) begin
      if (bdsz == m68k_ea_pkg::DSZ_LONG) extra = extra + 4'd6;
      else if (bdsz == m68k_ea_pkg::DSZ_WORD && ext[XB_BS]) extra = extra + 4'd2;
    end
    r.full_format_030 = cfg_is_030;
    iis = ext[2:0];
    if (iis == 3'd0) begin
      r.address      = base + bd + idx;
      r.extra_cycles = extra;
      return r;
    end
    // memory indirect: emit the read, hold what the data word needs
    extra = extra + 4'd4;
    post  = iis[2];
    odsz  = iis[1:0];
    od = (odsz == m68k_ea_pkg::DSZ_WORD) ? sx16(it.outer_disp_words[15:0]) :
         (odsz == m68k_ea_pkg::DSZ_LONG) ? it.outer_disp_words : 32'd0;
    if (cfg_is_030 && odsz >= m68k_ea_pkg::DSZ_WORD) extra = extra + 4'd2;
    r.result_kind  = m68k_ea_pkg::KIND_READ;
    r.address      = post ? (base + bd) : (base + bd + idx);
    r.extra_cycles = extra;
    ind_pend   = 1'b1;
    held_post  = post ? idx : 32'd0;
    held_outer = od;
    return r;
  endfunction

  // Expected result for one accepted word; updates the shadow state
  function automatic m68k_ea_pkg::result_t predict_ea(m68k_ea_pkg::item_t it);
    m68k_ea_pkg::result_t r;
    logic [31:0] an_step;
    r = '0;
    if (it.opcode == m68k_ea_pkg::OP_DATA) begin
      if (!ind_pend) begin
        r.result_kind = m68k_ea_pkg::KIND_INVALID;
      end else begin
        ind_pend  = 1'b0;
        r.address = it.mem_data + held_post + held_outer;
      end
      return r;
    end
    ind_pend = 1'b0;
    an_step = (it.size == m68k_ea_pkg::SIZE_BYTE) ?
                ((it.reg_req == m68k_ea_pkg::SP_REG) ? 32'd2 : 32'd1) :
              (it.size == m68k_ea_pkg::SIZE_WORD) ? 32'd2 : 32'd4;
    case (it.mode)
      m68k_ea_pkg::MODE_IND: begin
        r.address = it.an_value;
      end
      m68k_ea_pkg::MODE_POSTINC: begin
        r.address         = it.an_value;
        r.an_write_enable = 1'b1;
        r.an_new_value    = it.an_value + an_step;
      end
      m68k_ea_pkg::MODE_PREDEC: begin
        r.address         = it.an_value - an_step;
        r.an_write_enable = 1'b1;
        r.an_new_value    = it.an_value - an_step;
      end
      m68k_ea_pkg::MODE_DISP: begin
        r.address = it.an_value + sx16(it.ext_word);
      end
      m68k_ea_pkg::MODE_INDEX: begin
        r = index_form(it.an_value, it);
      end
      m68k_ea_pkg::MODE_EXT: begin
        case (it.reg_req)
          m68k_ea_pkg::SUB_ABS_SHORT: r.address = sx16(it.ext_word);
          m68k_ea_pkg::SUB_ABS_LONG:  r.address = it.base_disp_words;
          m68k_ea_pkg::SUB_PC_DISP:   r.address = it.pc_value + sx16(it.ext_word);
          m68k_ea_pkg::SUB_PC_INDEX:  r = index_form(it.pc_value, it);
          default:                    r.result_kind = m68k_ea_pkg::KIND_INVALID;
        endcase
      end
      default: begin
        r.result_kind = m68k_ea_pkg::KIND_INVALID;
      end
    endcase
    return r;
  endfunction

  function automatic m68k_ea_pkg::item_t rand_item();
    m68k_ea_pkg::item_t it;
    it.opcode           = m68k_ea_pkg::OP_COMPUTE;
    it.mode             = 3'($urandom_range(0, 7));
    it.reg_req          = 3'($urandom_range(0, 7));
    it.size             = 2'($urandom_range(0, 2));
    it.an_value         = $urandom;
    it.pc_value         = $urandom;
    it.ext_word         = 16'($urandom);
    it.index_value      = $urandom;
    it.base_disp_words  = $urandom;
    it.outer_disp_words = $urandom;
    it.mem_data         = $urandom;
    return it;
  endfunction

  function automatic m68k_ea_pkg::item_t mk(logic [2:0] mode, logic [2:0] rsel,
                                            logic [1:0] size, logic [15:0] ext);
    m68k_ea_pkg::item_t it;
    it          = rand_item();
    it.mode     = mode;
    it.reg_req  = rsel;
    it.size     = size;
    it.ext_word = ext;
    return it;
  endfunction

  function automatic m68k_ea_pkg::item_t mk_data();
    m68k_ea_pkg::item_t it;
    it        = rand_item();
    it.opcode = m68k_ea_pkg::OP_DATA;
    return it;
  endfunction

  // Directed: every mode and sub-mode, wrap-around, stack byte step, strays
  task automatic queue_directed();
    m68k_ea_pkg::item_t it;
    ea_items.push_back(mk(m68k_ea_pkg::MODE_IND, 3'd0, m68k_ea_pkg::SIZE_BYTE,
                          16'h0000));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_POSTINC, m68k_ea_pkg::SP_REG,
                          m68k_ea_pkg::SIZE_BYTE, 16'h0000));
    it = mk(m68k_ea_pkg::MODE_POSTINC, 3'd1, m68k_ea_pkg::SIZE_BYTE, 16'h0000);
    it.an_value = '1;
    ea_items.push_back(it);
    it = mk(m68k_ea_pkg::MODE_PREDEC, m68k_ea_pkg::SP_REG, m68k_ea_pkg::SIZE_BYTE,
            16'h0000);
    it.an_value = '0;
    ea_items.push_back(it);
    ea_items.push_back(mk(m68k_ea_pkg::MODE_PREDEC, 3'd2, SIZE_LONG, 16'h0000));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_DISP, 3'd4, m68k_ea_pkg::SIZE_WORD,
                          16'h8000));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_INDEX, 3'd3, SIZE_LONG, 16'h0680));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_INDEX, 3'd6, m68k_ea_pkg::SIZE_BYTE,
                          16'h087F));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_EXT, m68k_ea_pkg::SUB_ABS_SHORT,
                          m68k_ea_pkg::SIZE_WORD, 16'hFFFF));
    it = mk(m68k_ea_pkg::MODE_EXT, m68k_ea_pkg::SUB_ABS_LONG, SIZE_LONG, 16'h0000);
    it.base_disp_words = '1;
    ea_items.push_back(it);
    ea_items.push_back(mk(m68k_ea_pkg::MODE_EXT, m68k_ea_pkg::SUB_PC_DISP,
                          m68k_ea_pkg::SIZE_WORD, 16'h8001));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_EXT, m68k_ea_pkg::SUB_PC_INDEX,
                          m68k_ea_pkg::SIZE_BYTE, 16'hF6FF));
    ea_items.push_back(mk(MODE_DREG, 3'd0, SIZE_LONG, 16'h0000));
    ea_items.push_back(mk(MODE_AREG, 3'd7, m68k_ea_pkg::SIZE_WORD, 16'h0000));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_EXT, SUB_IMM, SIZE_LONG, 16'h0000));
    // data word with nothing pending
    ea_items.push_back(mk_data());
  endtask

  // Full extension formats, with and without memory indirection
  task automatic queue_full_forms();
    // suppressed base with word base displacement, no indirection
    ea_items.push_back(mk(m68k_ea_pkg::MODE_INDEX, 3'd1, m68k_ea_pkg::SIZE_WORD,
                          16'h01A0));
    // long base displacement, index suppressed, on the PC
    ea_items.push_back(mk(m68k_ea_pkg::MODE_EXT, m68k_ea_pkg::SUB_PC_INDEX,
                          SIZE_LONG, 16'h0F70));
    // pre-indexed, word outer displacement
    ea_items.push_back(mk(m68k_ea_pkg::MODE_INDEX, 3'd2, SIZE_LONG, 16'h0332));
    ea_items.push_back(mk_data());
    // post-indexed on the PC, long outer displacement
    ea_items.push_back(mk(m68k_ea_pkg::MODE_EXT, m68k_ea_pkg::SUB_PC_INDEX,
                          m68k_ea_pkg::SIZE_BYTE, 16'h0D27));
    ea_items.push_back(mk_data());
    // reserved I/IS 4 with reserved base displacement size 0
    ea_items.push_back(mk(m68k_ea_pkg::MODE_INDEX, 3'd5, m68k_ea_pkg::SIZE_WORD,
                          16'h0104));
    ea_items.push_back(mk_data());
    // index suppressed together with a post-indexed form
    ea_items.push_back(mk(m68k_ea_pkg::MODE_INDEX, 3'd0, m68k_ea_pkg::SIZE_WORD,
                          16'h0155));
    ea_items.push_back(mk_data());
    // a compute word in between drops the pending indirection
    ea_items.push_back(mk(m68k_ea_pkg::MODE_INDEX, 3'd7, SIZE_LONG, 16'h0191));
    ea_items.push_back(mk(m68k_ea_pkg::MODE_IND, 3'd3, SIZE_LONG, 16'h0000));
    ea_items.push_back(mk_data());
  endtask

  // Random words: mostly indirect sequences, some plain modes, some noise
  task automatic queue_random(input int unsigned n);
    m68k_ea_pkg::item_t it;
    int unsigned        sel;
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      it  = rand_item();
      if (sel < 60) begin
        it.ext_word[XB_FULL] = 1'b1;
        if ($urandom_range(0, 1) == 0) begin
          it.mode = m68k_ea_pkg::MODE_INDEX;
        end else begin
          it.mode    = m68k_ea_pkg::MODE_EXT;
          it.reg_req = m68k_ea_pkg::SUB_PC_INDEX;
        end
        if (sel < 45) begin
          if (it.ext_word[2:0] == 3'd0) it.ext_word[2:0] = 3'($urandom_range(1, 7));
          ea_items.push_back(it);
          // now and then the data word never comes
          if ($urandom_range(0, 9) != 0) begin
            ea_items.push_back(mk_data());
            k++;
          end
        end else begin
          it.ext_word[2:0] = 3'd0;
          ea_items.push_back(it);
        end
      end else if (sel < 88) begin
        ea_items.push_back(it);
      end else begin
        it.opcode = 1'($urandom_range(0, 1));
        ea_items.push_back(it);
      end
    end
  endtask

  // Register write: setup cycle, then access cycle
  task automatic cfg_write(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= m68k_ea_pkg::CfgAddrW'(4 * int'(m68k_ea_pkg::REG_CPU));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    cfg_is_030 = value[0];
  endtask

  // Sampled between edges so the driver's queue and tvalid agree
  task automatic wait_idle();
    @(negedge clk_i);
    while (ea_items.size() != 0 || ea_expected.size() != 0 || s_tvalid) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    m68k_ea_pkg::result_t want;
    results_out++;
    if (m_tuser == m68k_ea_pkg::KIND_READ) reads_out++;
    if (m_tuser == m68k_ea_pkg::KIND_INVALID) invalid_out++;
    if (ea_expected.size() == 0) begin
      $error("unexpected result word: kind %0d address 0x%0h", m_tuser, m_tdata[31:0]);
      mismatch_cnt++;
      return;
    end
    want = ea_expected.pop_front();
    cmp_field("result_kind", 32'(want.result_kind), 32'(m_tuser));
    cmp_field("address", want.address, m_tdata[31:0]);
    cmp_field("an_write_enable", 32'(want.an_write_enable), 32'(m_tdata[32]));
    cmp_field("an_new_value", want.an_new_value, m_tdata[64:33]);
    cmp_field("extra_cycles", 32'(want.extra_cycles), 32'(m_tdata[68:65]));
    cmp_field("ext020_used", 32'(want.ext020_used), 32'(m_tdata[69]));
    cmp_field("full_format_030", 32'(want.full_format_030), 32'(m_tdata[70]));
  endtask

  // Input driver: predict on acceptance, then offer the next word after a gap
  m68k_ea_pkg::item_t cur_item;
  logic [3:0]         tx_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      tx_gap   <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        ea_expected.push_back(predict_ea(cur_item));
        words_in++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap != 4'd0) begin
          s_tvalid <= 1'b0;
          tx_gap   <= tx_gap - 4'd1;
        end else if (ea_items.size() != 0) begin
          cur_item = ea_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur_item.opcode;
          s_tdata  <= {cur_item.mem_data, cur_item.outer_disp_words,
                       cur_item.base_disp_words, cur_item.index_value,
                       cur_item.ext_word, cur_item.pc_value, cur_item.an_value,
                       cur_item.size, cur_item.reg_req, cur_item.mode};
          tx_gap   <= 4'($urandom_range(0, tx_gap_max));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each word, then stall for a drawn number of cycles
  logic [7:0]  rx_wait;
  int unsigned rx_draw;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_wait  <= '0;
      hold_ack <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (hold_ack != hold_req) begin
        // long hold-off so the block backs up into its input
        hold_ack <= hold_req;
        rx_wait  <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        rx_draw = $urandom_range(0, rx_gap_max);
        rx_wait  <= 8'(rx_draw);
        m_tready <= (rx_draw == 0);
      end else if (rx_wait != 8'd0) begin
        rx_wait  <= rx_wait - 8'd1;
        m_tready <= (rx_wait == 8'd1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 68040 timing: directed words, then random with idling on both sides
    cfg_write(32'd0);
    tx_gap_max = 15;
    rx_gap_max = 15;
    queue_directed();
    queue_full_forms();
    wait_idle();
    queue_random(150);
    wait_idle();

    // 68030 timing: back to back, receiver holds off at the start
    cfg_write(32'd1);
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_req++;
    queue_full_forms();
    queue_random(150);
    wait_idle();

    // 68040 timing, sender idles
    cfg_write(32'd0);
    tx_gap_max = 15;
    rx_gap_max = 0;
    queue_random(100);
    wait_idle();

    // 68030 timing, receiver idles
    cfg_write(32'd1);
    tx_gap_max = 0;
    rx_gap_max = 15;
    queue_random(100);
    wait_idle();
    repeat (8) @(posedge clk_i);

    if (ea_expected.size() != 0) begin
      $error("%0d expected results never arrived", ea_expected.size());
      mismatch_cnt++;
    end
    $display("Run: %0d words in, %0d results out (%0d read requests, %0d invalid),",
             words_in, results_out, reads_out, invalid_out);
    $display("     both timing settings, idle and back-to-back streams, long result stall.");
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/m68k_ea_pkg.sv
rtl/core/m68k_ea_calc.sv
rtl/core/m68k_effective_address_unit.sv
sim/tb_m68k_effective_address_unit.sv
